// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds only outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");

// check that also covers the reset cycles
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");

`endif

// ===== rtl/bslp_pkg.sv =====
// ----------------------------------------------------------------------------
// bslp_pkg
// types, codes and reset values of the button press controller
// ----------------------------------------------------------------------------
package bslp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TALK_GROUP   = 2'd2;

  localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd50;
  localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd1000;
  localparam logic [7:0]  MAX_TALK_GROUP_RST   = 8'd16;
  localparam logic [7:0]  TALK_GROUP_RST       = 8'd1;

  localparam int PRESS_TIMER_BITS_DEF = 16;
  localparam int SINCE_W              = 9;

  // mode codes
  localparam logic [1:0] MD_LOCAL  = 2'd0;
  localparam logic [1:0] MD_REMOTE = 2'd1;
  localparam logic [1:0] MD_AUTO   = 2'd2;

  // button event codes
  localparam logic [2:0] BEV_NONE      = 3'd0;
  localparam logic [2:0] BEV_TG_ADV    = 3'd1;
  localparam logic [2:0] BEV_TO_REMOTE = 3'd2;
  localparam logic [2:0] BEV_TO_AUTO   = 3'd3;
  localparam logic [2:0] BEV_TO_LOCAL  = 3'd4;

  // push-to-talk event codes
  localparam logic [1:0] PEV_NONE  = 2'd0;
  localparam logic [1:0] PEV_START = 2'd1;
  localparam logic [1:0] PEV_STOP  = 2'd2;

  typedef struct packed {
    logic func_button_level;
    logic ptt_button_level;
  } in_word_t;

  typedef struct packed {
    logic [2:0] button_event;
    logic [1:0] ptt_event;
    logic [7:0] talk_group_out;
    logic [1:0] mode_out;
    logic       transmitting_out;
    logic       ptt_led;
  } out_word_t;

endpackage

// ===== rtl/button_short_long_press_controller.sv =====
// ----------------------------------------------------------------------------
// button_short_long_press_controller
// debounced function button with short/long press detection and push-to-talk
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid/in_ready/in_data): one word per millisecond tick,
//     carrying the raw active-low function and push-to-talk levels
//   out channel (out_valid/out_ready/out_data): exactly one word per tick,
//     with button and push-to-talk event codes, talk group, mode, transmit
//     state and the push-to-talk led
//   cfg port (cfg_wr_en/cfg_index/cfg_data): debounce time, long press time
//     and highest talk group; write only while no tick is in flight
// latency: two cycles from input accept to output valid (input register,
//   then the single-pass update into the output register)
// throughput: one word per cycle; every update is a few increments and
//   compares on narrow counters, done in the cycle the word leaves the
//   input register
// reset (synchronous, rst_n low): both stages empty, timers cleared, levels
//   released, talk group 1, local mode, not transmitting, config at defaults
// stall: while out_ready is low a pending result holds; the input register
//   still takes one more word, after which in_ready drops until the output
//   slot frees
// ----------------------------------------------------------------------------
module button_short_long_press_controller #(
  parameter int PRESS_TIMER_BITS = bslp_pkg::PRESS_TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bslp_pkg::in_word_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output bslp_pkg::out_word_t            out_data,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [bslp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // compare width wide enough for both the press timer and the threshold
  localparam int CMP_W = (PRESS_TIMER_BITS > 16) ? PRESS_TIMER_BITS : 16;
  localparam logic [PRESS_TIMER_BITS-1:0] PRESS_MAX = '1;
  localparam logic [bslp_pkg::SINCE_W-1:0] SINCE_MAX = '1;

  // config registers
  logic [7:0]  debounce_ticks_r;
  logic [15:0] long_press_ticks_r;
  logic [7:0]  max_talk_group_r;

  // input stage
  logic               s1_valid_r;
  bslp_pkg::in_word_t s1_word_r;

  // output stage
  logic                out_valid_r;
  bslp_pkg::out_word_t out_word_r;
  bslp_pkg::out_word_t out_word_nxt;

  // tick state
  logic                          last_raw_r, last_raw_nxt;
  logic                          stable_r, stable_nxt;
  logic [bslp_pkg::SINCE_W-1:0]  since_r, since_nxt;
  logic [PRESS_TIMER_BITS-1:0]   press_r, press_nxt;
  logic                          long_fired_r, long_fired_nxt;
  logic [7:0]                    talk_group_r, talk_group_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic                          tx_r, tx_nxt;

  // combinational helpers
  logic             advance;
  logic             raw;
  logic             ptt;
  logic             debounced;
  logic [8:0]       tg_plus;
  logic [CMP_W-1:0] press_inc_cmp;
  logic [CMP_W-1:0] press_nxt_cmp;
  logic [CMP_W-1:0] long_cmp;
  logic [2:0]       bev;
  logic [1:0]       pev;

  // output slot frees when empty or being taken this cycle
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign raw = s1_word_r.func_button_level;
  assign ptt = !s1_word_r.ptt_button_level;

  always_comb begin
    last_raw_nxt   = raw;
    stable_nxt     = stable_r;
    long_fired_nxt = long_fired_r;
    talk_group_nxt = talk_group_r;
    mode_nxt       = mode_r;
    tx_nxt         = tx_r;
    bev            = bslp_pkg::BEV_NONE;
    pev            = bslp_pkg::PEV_NONE;

    // hold-time counter, saturating
    if (raw != last_raw_r) begin
      since_nxt = '0;
    end else if (since_r != SINCE_MAX) begin
      since_nxt = since_r + 1'b1;
    end else begin
      since_nxt = since_r;
    end

    // press timer, saturating
    if (press_r != PRESS_MAX) begin
      press_nxt = press_r + 1'b1;
    end else begin
      press_nxt = press_r;
    end

    debounced     = since_nxt > {1'b0, debounce_ticks_r};
    long_cmp      = CMP_W'(long_press_ticks_r);
    press_inc_cmp = CMP_W'(press_nxt);
    tg_plus       = {1'b0, talk_group_r} + 9'd1;

    if (debounced) begin
      if (raw != stable_r) begin
        stable_nxt = raw;
        if (!raw) begin
          // new press starts timing
          press_nxt      = '0;
          long_fired_nxt = 1'b0;
        end else if (!long_fired_r && (press_inc_cmp < long_cmp)) begin
          // short press released
          talk_group_nxt = (tg_plus > {1'b0, max_talk_group_r}) ?
                           bslp_pkg::TALK_GROUP_RST : tg_plus[7:0];
          bev            = bslp_pkg::BEV_TG_ADV;
        end
      end
    end

    press_nxt_cmp = CMP_W'(press_nxt);

    if (debounced && !stable_nxt && !long_fired_nxt && (press_nxt_cmp >= long_cmp)) begin
      // long press fires once per press
      long_fired_nxt = 1'b1;
      unique case (mode_r)
        bslp_pkg::MD_LOCAL: begin
          mode_nxt = bslp_pkg::MD_REMOTE;
          bev      = bslp_pkg::BEV_TO_REMOTE;
        end
        bslp_pkg::MD_REMOTE: begin
          mode_nxt = bslp_pkg::MD_AUTO;
          bev      = bslp_pkg::BEV_TO_AUTO;
        end
        default: begin
          // auto and the unused code both go back to local
          mode_nxt = bslp_pkg::MD_LOCAL;
          bev      = bslp_pkg::BEV_TO_LOCAL;
        end
      endcase
    end

    // push-to-talk runs after the button step, local mode only
    priority if (mode_nxt != bslp_pkg::MD_LOCAL) begin
      tx_nxt = 1'b0;
    end else if (ptt && !tx_r) begin
      tx_nxt = 1'b1;
      pev    = bslp_pkg::PEV_START;
    end else if (!ptt && tx_r) begin
      tx_nxt = 1'b0;
      pev    = bslp_pkg::PEV_STOP;
    end else begin
      tx_nxt = tx_r;
    end

    out_word_nxt.button_event     = bev;
    out_word_nxt.ptt_event        = pev;
    out_word_nxt.talk_group_out   = talk_group_nxt;
    out_word_nxt.mode_out         = mode_nxt;
    out_word_nxt.transmitting_out = tx_nxt;
    out_word_nxt.ptt_led          = ptt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= bslp_pkg::DEBOUNCE_TICKS_RST;
      long_press_ticks_r <= bslp_pkg::LONG_PRESS_TICKS_RST;
      max_talk_group_r   <= bslp_pkg::MAX_TALK_GROUP_RST;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      last_raw_r         <= 1'b1;
      stable_r           <= 1'b1;
      since_r            <= '0;
      press_r            <= '0;
      long_fired_r       <= 1'b0;
      talk_group_r       <= bslp_pkg::TALK_GROUP_RST;
      mode_r             <= bslp_pkg::MD_LOCAL;
      tx_r               <= 1'b0;
    end else begin
      // config writes, out-of-range index ignored
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bslp_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_data[7:0];
          bslp_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_data[15:0];
          bslp_pkg::CFG_MAX_TALK_GROUP:   max_talk_group_r   <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      // single-pass update as the word moves into the output register
      if (s1_valid_r && advance) begin
        out_valid_r  <= 1'b1;
        last_raw_r   <= last_raw_nxt;
        stable_r     <= stable_nxt;
        since_r      <= since_nxt;
        press_r      <= press_nxt;
        long_fired_r <= long_fired_nxt;
        talk_group_r <= talk_group_nxt;
        mode_r       <= mode_nxt;
        tx_r         <= tx_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
    if (s1_valid_r && advance) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

// ===== rtl/bslp_checker.sv =====
// ----------------------------------------------------------------------------
// bslp_checker
// port-level checks of the button press controller, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bslp_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bslp_pkg::out_word_t out_data
);

  // nothing left in flight after reset
  `ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid && in_ready)

  // stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // transmit only in local mode
  `ASSERT_CLK(a_tx_local, out_valid && out_data.transmitting_out |-> out_data.mode_out == bslp_pkg::MD_LOCAL)

  // talk group never zero
  `ASSERT_CLK(a_tg_nonzero, out_valid |-> out_data.talk_group_out != 8'd0)

  // a start event leaves transmit on
  `ASSERT_CLK(a_start_tx, out_valid && out_data.ptt_event == bslp_pkg::PEV_START |-> out_data.transmitting_out)

endmodule

bind button_short_long_press_controller bslp_props u_bslp_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
